// File: src/rmbb_pkg.sv
// Shared types and constants for the RLE mask bounding box block.
// Used by rmbb_div and rle_mask_bounding_box; depends on nothing else.
package rmbb_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEPS  = DIVIDEND_W;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

    // Status of the shared serial divider as seen by its sequencer.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_status_t;

endpackage

// File: src/rle_mask_bounding_box.sv
// Bounding box of a column-major run-length-encoded binary mask.
// Depends on rmbb_pkg and on the serial divider rmbb_div.
//
// Usage:
//   The slave stream carries one run length per transaction in s_tdata, zeros
//   and ones runs alternating and starting with zeros; s_tlast marks the last
//   run of a mask. On that transaction the master stream carries one box in
//   m_tdata. Other transactions produce no output.
//   The configuration port writes image_height (index 0); image_width
//   (index 1) is accepted but does not change the box. A height of zero acts
//   as one. Write registers only while the block is idle.
// Timing:
//   A zeros run is accepted every cycle while the block is idle. A ones run
//   keeps s_tready low through two divisions on the shared divider, for its
//   start and then its end pixel, and a merge of the pixels into the box.
//   A last run then loads the box into the output register, which holds it
//   until m_tready; new runs are accepted meanwhile, and the next last run
//   waits, with s_tready low, for the register to be free.
// Reset clears the running position and the box, drops m_tvalid and sets
// the height to one.
module rle_mask_bounding_box #(
    parameter int DIM_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] run_length
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // box_x, box_y, box_width, box_height
    input  logic                              cfg_wr_en,
    input  logic [rmbb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [15:0]                       cfg_wdata
);
    import rmbb_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV_START = 3'd1;
    localparam logic [2:0] ST_DIV_END   = 3'd2;
    localparam logic [2:0] ST_UPDATE    = 3'd3;
    localparam logic [2:0] ST_FINISH    = 3'd4;

    localparam logic [31:0]         DIM_MAX32 = (32'd1 << DIM_BITS) - 32'd1;
    localparam logic [DIM_BITS-1:0] DIM_MAX   = '1;

    typedef logic [DIM_BITS-1:0] dim_t;

    function automatic dim_t sat_dim(input logic [31:0] v);
        return (v > DIM_MAX32) ? DIM_MAX : v[DIM_BITS-1:0];
    endfunction

    function automatic dim_t dmin(input dim_t a, input dim_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic dim_t dmax(input dim_t a, input dim_t b);
        return (a > b) ? a : b;
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [31:0] pos_reg, pos_next;
    logic        parity_reg, parity_next;
    logic        any_ones_reg, any_ones_next;
    dim_t        min_col_reg, min_col_next;
    dim_t        max_col_reg, max_col_next;
    dim_t        min_row_reg, min_row_next;
    dim_t        max_row_reg, max_row_next;
    dim_t        start_col_reg, start_col_next;
    dim_t        start_row_reg, start_row_next;
    dim_t        end_col_reg, end_col_next;
    dim_t        end_row_reg, end_row_next;
    logic [31:0] end_pos_reg, end_pos_next;
    logic        last_reg, last_next;
    logic [15:0] height_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic [15:0]       h_eff;
    dim_t              h_last_row;
    logic              s_fire;
    logic              out_free;
    logic              div_start;
    logic [31:0]       div_dividend;
    div_status_t       div_status;
    logic              crosses;
    dim_t              row_lo, row_hi, row_max_pair;
    logic [DIM_BITS:0] box_w, box_h;

    assign h_eff      = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign h_last_row = sat_dim(32'(h_eff - 16'd1));
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // The divider serves the start pixel of a ones run first, then its end pixel.
    assign div_start    = (s_fire && parity_reg) ||
                          (state_reg == ST_DIV_START && div_status.done);
    assign div_dividend = (state_reg == ST_IDLE) ? pos_reg : end_pos_reg;

    rmbb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (h_eff),
        .status   (div_status)
    );

    always_comb begin
        // A ones run that ends in a later column than it starts covers full columns.
        crosses      = start_col_reg < end_col_reg;
        row_max_pair = dmax(start_row_reg, end_row_reg);
        row_lo       = crosses ? '0 : dmin(start_row_reg, end_row_reg);
        row_hi       = crosses ? dmax(h_last_row, row_max_pair) : row_max_pair;

        box_w = {1'b0, max_col_reg} - {1'b0, min_col_reg} + (DIM_BITS+1)'(1);
        box_h = {1'b0, max_row_reg} - {1'b0, min_row_reg} + (DIM_BITS+1)'(1);
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        parity_next    = parity_reg;
        any_ones_next  = any_ones_reg;
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        max_row_next   = max_row_reg;
        start_col_next = start_col_reg;
        start_row_next = start_row_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        end_pos_next   = end_pos_reg;
        last_next      = last_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pos_next  = pos_reg + s_tdata;
                    last_next = s_tlast;
                    if (!parity_reg) begin
                        parity_next = 1'b1;
                        state_next  = s_tlast ? ST_FINISH : ST_IDLE;
                    end else begin
                        end_pos_next = pos_reg + s_tdata - 32'd1;
                        state_next   = ST_DIV_START;
                    end
                end
            end
            ST_DIV_START: begin
                if (div_status.done) begin
                    start_col_next = sat_dim(div_status.quotient);
                    start_row_next = sat_dim(32'(div_status.remainder));
                    state_next     = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                if (div_status.done) begin
                    end_col_next = sat_dim(div_status.quotient);
                    end_row_next = sat_dim(32'(div_status.remainder));
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                min_col_next  = dmin(min_col_reg, dmin(start_col_reg, end_col_reg));
                max_col_next  = dmax(max_col_reg, dmax(start_col_reg, end_col_reg));
                min_row_next  = dmin(min_row_reg, row_lo);
                max_row_next  = dmax(max_row_reg, row_hi);
                any_ones_next = 1'b1;
                parity_next   = 1'b0;
                state_next    = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (any_ones_reg) begin
                        m_tdata_next = {
                            16'(box_h[DIM_BITS] ? DIM_MAX : box_h[DIM_BITS-1:0]),
                            16'(box_w[DIM_BITS] ? DIM_MAX : box_w[DIM_BITS-1:0]),
                            16'(min_row_reg),
                            16'(min_col_reg)
                        };
                    end else begin
                        m_tdata_next = '0;
                    end
                    pos_next       = '0;
                    parity_next    = 1'b0;
                    any_ones_next  = 1'b0;
                    min_col_next   = DIM_MAX;
                    max_col_next   = '0;
                    min_row_next   = DIM_MAX;
                    max_row_next   = '0;
                    start_col_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            parity_reg    <= 1'b0;
            any_ones_reg  <= 1'b0;
            min_col_reg   <= DIM_MAX;
            max_col_reg   <= '0;
            min_row_reg   <= DIM_MAX;
            max_row_reg   <= '0;
            start_col_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            parity_reg    <= parity_next;
            any_ones_reg  <= any_ones_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            start_col_reg <= start_col_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_row_reg <= start_row_next;
        end_col_reg   <= end_col_next;
        end_row_reg   <= end_row_next;
        end_pos_reg   <= end_pos_next;
        last_reg      <= last_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                // The mask width does not enter the box, so it is not kept.
                REG_IMAGE_WIDTH:  height_reg <= height_reg;
                default:          height_reg <= height_reg;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_status.busy)
        else $error("input accepted while the divider is busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && parity_reg) |=> (state_reg == ST_DIV_START && div_status.busy))
        else $error("ones run did not start its first division");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[47:32] == 16'd0) == (m_tdata[63:48] == 16'd0)))
        else $error("box has zero width or height but not both");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && any_ones_reg) |->
            (min_col_reg <= max_col_reg && min_row_reg <= max_row_reg))
        else $error("box bounds out of order");

endmodule

// File: src/rmbb_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on rmbb_pkg for widths and the status struct.
module rmbb_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [rmbb_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [rmbb_pkg::DIVISOR_W-1:0]      divisor,
    output rmbb_pkg::div_status_t               status
);
    import rmbb_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = rem_shift - {1'b0, div_reg};
        fits      = rem_shift >= {1'b0, div_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;

        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so 16 bits hold it.
            rem_next   = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign status.busy      = busy_reg;
    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule

// File: verif/rle_mask_bounding_box_tb.sv
// Self-checking testbench for rle_mask_bounding_box: streams run-length masks,
// predicts each box in place and checks every box that leaves the block.
// Depends on rmbb_pkg and the RTL of rle_mask_bounding_box and rmbb_div only.
`timescale 1ns / 1ps

module rle_mask_bounding_box_tb;
    import rmbb_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 80;
    localparam int PHASE_RUNS  = 230;
    localparam int MAX_PRINTS  = 60;

    // Box fields, lowest 16 bits of m_tdata first.
    localparam int BOX_X = 0;
    localparam int BOX_Y = 1;
    localparam int BOX_W = 2;
    localparam int BOX_H = 3;

    typedef bit [3:0][15:0] box_t;
    typedef struct packed {
        bit [31:0] len;
        bit        last;
    } run_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [15:0]           cfg_wdata = '0;

    run_t        run_q[$];
    box_t        box_q[$];
    run_t        next_run;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count      = 0;
    int unsigned cycle_count    = 0;

    // Predictor copy of the height register and of the per-mask state.
    bit [15:0] cfg_height = 16'd1;
    bit [31:0] pos_acc    = '0;
    bit        want_ones  = 1'b0;
    bit        seen_ones  = 1'b0;
    bit [15:0] col_lo     = 16'hFFFF;
    bit [15:0] col_hi     = 16'h0000;
    bit [15:0] row_lo     = 16'hFFFF;
    bit [15:0] row_hi     = 16'h0000;

    rle_mask_bounding_box u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        // Printing is capped so a badly broken block cannot flood the log.
        if (err_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    function automatic bit [15:0] clip_dim(input bit [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic widen_box(input bit [15:0] col, input bit [15:0] row);
        if (col < col_lo) col_lo = col;
        if (col > col_hi) col_hi = col;
        if (row < row_lo) row_lo = row;
        if (row > row_hi) row_hi = row;
    endtask

    // Advances the predicted mask state by one run; a last run yields one box.
    task automatic track_run(input bit [31:0] len, input bit last);
        bit [31:0] h;
        bit [31:0] start;
        bit [31:0] stop;
        bit [15:0] c_start;
        bit [15:0] c_stop;
        box_t      box;
        h = (cfg_height == 16'd0) ? 32'd1 : {16'd0, cfg_height};
        if (!want_ones) begin
            pos_acc   = pos_acc + len;
            want_ones = 1'b1;
        end else begin
            start   = pos_acc;
            pos_acc = pos_acc + len;
            stop    = pos_acc - 32'd1;
            c_start = clip_dim(start / h);
            c_stop  = clip_dim(stop / h);
            widen_box(c_start, clip_dim(start % h));
            // A ones run that spills into a later column covers the full height.
            if (c_start < c_stop) begin
                widen_box(c_stop, 16'd0);
                widen_box(c_stop, clip_dim(h - 32'd1));
            end
            widen_box(c_stop, clip_dim(stop % h));
            seen_ones = 1'b1;
            want_ones = 1'b0;
        end
        if (last) begin
            box = '0;
            if (seen_ones) begin
                box[BOX_X] = col_lo;
                box[BOX_Y] = row_lo;
                box[BOX_W] = clip_dim({16'd0, col_hi} - {16'd0, col_lo} + 32'd1);
                box[BOX_H] = clip_dim({16'd0, row_hi} - {16'd0, row_lo} + 32'd1);
            end
            box_q.push_back(box);
            pos_acc   = '0;
            want_ones = 1'b0;
            seen_ones = 1'b0;
            col_lo    = 16'hFFFF;
            col_hi    = 16'h0000;
            row_lo    = 16'hFFFF;
            row_hi    = 16'h0000;
        end
    endtask

    // Driver: one run per transaction, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_run(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (run_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_run = run_q.pop_front();
                    s_tdata  <= next_run.len;
                    s_tlast  <= next_run.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each box transaction with the oldest predicted box.
    always @(posedge aclk) begin : box_monitor
        box_t  got;
        box_t  want;
        string field_name[4];
        field_name = '{"box_x", "box_y", "box_width", "box_height"};
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = box_t'(m_tdata);
                if (box_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected box 0x%016h", m_tdata));
                end else begin
                    want = box_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[i] != want[i])
                            report_mismatch($sformatf("%s got %0d expected %0d",
                                                      field_name[i], got[i], want[i]));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input bit [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // The width register does not enter the box, so only the height is tracked.
        if (idx == REG_IMAGE_HEIGHT)
            cfg_height = val;
    endtask

    // Blocks until every queued run has gone in and every box has come out,
    // then gives the block time to finish any run that yields no box.
    task automatic wait_drained();
        @(negedge aclk);
        while (run_q.size() != 0 || s_tvalid || box_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_run(input bit [31:0] len, input bit last);
        run_t r;
        r.len  = len;
        r.last = last;
        run_q.push_back(r);
    endtask

    // Queues one mask of random shape; lengths mostly stay within a few
    // columns so boxes are meaningful, with some zero and full-range runs.
    task automatic queue_mask(input int unsigned h_eff, inout int unsigned runs);
        int unsigned n;
        bit [31:0]   len;
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0:       len = $urandom();
                1:       len = 32'd0;
                2:       len = 32'hFFFF_FFFF;
                3, 4, 5: len = $urandom_range(0, h_eff * 40);
                default: len = $urandom_range(0, h_eff * 3);
            endcase
            add_run(len, i == n - 1);
        end
        runs += n;
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    initial begin : stimulus
        bit [15:0]   heights[8];
        bit [15:0]   widths[8];
        int unsigned h_eff;
        int unsigned runs;
        heights = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd2, 16'd0, 16'd4096, 16'd0};
        widths  = '{16'd65535, 16'd1, 16'd0, 16'd300, 16'd0, 16'd0, 16'd65535, 16'd0};
        heights[5] = 16'($urandom_range(3, 64));
        heights[7] = 16'($urandom_range(100, 5000));
        widths[5]  = 16'($urandom());
        widths[7]  = 16'($urandom());

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_IMAGE_HEIGHT, 16'd10);
        write_reg(REG_IMAGE_WIDTH, 16'd20);
        set_idling(0);
        // A lone zeros run gives an empty box.
        add_run(32'd5, 1'b1);
        // One ones run inside column 0.
        add_run(32'd3, 1'b0);
        add_run(32'd4, 1'b1);
        // A ones run crossing into the next column, then a trailing zeros run.
        add_run(32'd8, 1'b0);
        add_run(32'd5, 1'b0);
        add_run(32'd20, 1'b1);
        // Maximal ones run: the end column saturates.
        add_run(32'd0, 1'b0);
        add_run(32'hFFFF_FFFF, 1'b1);
        // Position wraps past 2^32 within the ones run.
        add_run(32'hFFFF_FFFF, 1'b0);
        add_run(32'd2, 1'b1);
        // Zero-length ones run: its end pixel wraps to the top of the range.
        add_run(32'd0, 1'b0);
        add_run(32'd0, 1'b1);
        // Two pairs widen one box.
        add_run(32'd12, 1'b0);
        add_run(32'd1, 1'b0);
        add_run(32'd30, 1'b0);
        add_run(32'd9, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_IMAGE_HEIGHT, heights[p]);
            write_reg(REG_IMAGE_WIDTH, widths[p]);
            set_idling(p + 1);
            h_eff = (heights[p] == 16'd0) ? 1 : heights[p];
            runs  = 0;
            while (runs < PHASE_RUNS)
                queue_mask(h_eff, runs);
            wait_drained();
        end

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
src/rmbb_pkg.sv
src/rmbb_div.sv
src/rle_mask_bounding_box.sv
verif/rle_mask_bounding_box_tb.sv
